[rtl/core/bitmap_frame_allocator_defines.svh]
// Assertion macros for the bitmap frame allocator.
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BFA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/bfa_pkg.sv]
// Shared types and constants for the bitmap frame allocator.
package bfa_pkg;

    localparam int WORD_BITS = 32;
    localparam logic [WORD_BITS-1:0] FULL_WORD = '1;
    localparam int MEM_KB_W = 18;
    localparam logic [MEM_KB_W-1:0] MEM_KB_RESET = 18'h20000;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_FREE    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_RESERVE = 2'd3;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NO_MEM = 2'd1;
    localparam logic [1:0] STATUS_RANGE  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] length;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] block_addr;
        logic [15:0] free_blocks;
    } rsp_item_t;

    // Datapath command, one per cycle
    typedef enum logic [3:0] {
        DP_NONE,
        DP_INIT,
        DP_ACCEPT,
        DP_SETUP,
        DP_SCAN,
        DP_FREE,
        DP_REGION,
        DP_FORCE_RD,
        DP_FORCE_WR,
        DP_LOAD
    } dp_op_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       init_last;
        logic       alloc_fail;
        logic       free_ok;
        logic       region_live;
        logic       word_full;
        logic       scan_more;
        logic       region_more;
    } dp_status_t;

endpackage

[rtl/core/bitmap_frame_allocator.sv]
// Bitmap frame allocator: one used bit per block plus a free-block count.
//
// Requests come in on req_valid/req_ready with req_data (kind, addr, length);
// one response per request leaves on rsp_valid/rsp_ready with rsp_data
// (status, block_addr, free_blocks). cfg_valid/cfg_data writes memory_kb;
// cfg_ready is always high and writes belong between requests.
// One request is worked at a time, one map word per cycle. A free reads the
// block's word, clears its bit and answers (out of range: it answers without
// touching the map). An allocate scans words up to the first word with a clear
// bit. A reserve or release walks the map words the run touches, and a release
// then rewrites block 0 as used. req_ready rises at the edge that loads the
// response (rsp_valid rises), so the next request can be taken in the cycle
// after at the earliest, even while the response still waits; if the old
// response is still not taken when the next one is done, work halts before
// the load. After reset the map is swept to all used, one word per cycle,
// with req_ready low; the free count and memory_kb return to their reset
// values. BLOCK_BYTES and NUM_BLOCKS are powers of two.
module bitmap_frame_allocator #(
    parameter int NUM_BLOCKS  = 32768,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  bfa_pkg::req_item_t             req_data,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output bfa_pkg::rsp_item_t             rsp_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bfa_pkg::MEM_KB_W-1:0]   cfg_data
);

    `include "bitmap_frame_allocator_defines.svh"

    bfa_pkg::dp_op_t     dp_cmd;
    bfa_pkg::dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .dp_status (dp_status),
        .op        (dp_cmd)
    );

    bfa_datapath #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (dp_cmd),
        .dp_status (dp_status),
        .req_data  (req_data),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data)
    );

    `BFA_ASSERT_IMPLY(a_load_no_overwrite, dp_cmd == bfa_pkg::DP_LOAD,
        !rsp_valid || rsp_ready, "response overwritten before taken")
    `BFA_ASSERT_IMPLY(a_accept_only_ready, dp_cmd == bfa_pkg::DP_ACCEPT,
        req_valid && req_ready, "request latched without handshake")
    `BFA_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready,
        !req_ready, "second request taken while busy")
    `BFA_ASSERT_IMPLY(a_fail_addr_zero, rsp_valid && rsp_data.status != bfa_pkg::STATUS_OK,
        rsp_data.block_addr == 32'd0, "failed response carries an address")

endmodule

[rtl/core/bfa_datapath.sv]
// Datapath: used map memory, free count, request and response registers.
module bfa_datapath #(
    parameter int NUM_BLOCKS  = 32768,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bfa_pkg::dp_op_t                op,
    output bfa_pkg::dp_status_t            dp_status,
    input  bfa_pkg::req_item_t             req_data,
    output bfa_pkg::rsp_item_t             rsp_data,
    input  logic                           cfg_valid,
    input  logic [bfa_pkg::MEM_KB_W-1:0]   cfg_data
);

    localparam int S         = $clog2(BLOCK_BYTES);
    localparam int FW        = 32 - S;
    localparam int EW        = FW + 1;
    localparam int MAP_WORDS = NUM_BLOCKS / bfa_pkg::WORD_BITS;
    localparam int IDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNTW      = $clog2(NUM_BLOCKS + 1);
    localparam int CW1       = CNTW + 1;
    localparam int KBW       = bfa_pkg::MEM_KB_W + 10;

    logic [31:0]             mem [MAP_WORDS];
    logic [31:0]             rdata_reg;

    logic [1:0]              kind_reg;
    logic [FW-1:0]           start_reg;
    logic [EW-1:0]           end_reg;
    logic                    len_nz_reg;
    logic [CNTW-1:0]         stop_reg;
    logic [CNTW-1:0]         n_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [1:0]              status_reg;
    logic [31:0]             baddr_reg;
    bfa_pkg::rsp_item_t      rsp_reg;

    logic [IDX_W-1:0]        clr_reg;
    logic [CNTW-1:0]         cnt_reg;
    logic [CNTW-1:0]         cnt_next;
    logic [bfa_pkg::MEM_KB_W-1:0] memory_kb_reg;

    logic [KBW-1:0]          tot_raw;
    logic [CNTW-1:0]         total;
    logic [63:0]             total_ext;
    logic [CNTW-1:0]         nwords;
    logic [63:0]             start_ext;
    logic [63:0]             end_ext;
    logic [IDX_W-1:0]        start_word;
    logic [CNTW-1:0]         stop;
    logic [CNTW-1:0]         last_frame;
    logic [63:0]             last_ext;
    logic [IDX_W-1:0]        last_word;
    logic [4:0]              lo;
    logic [4:0]              hi;
    logic [31:0]             region_mask;
    logic [4:0]              zero_bit;
    logic [63:0]             frame_ext;
    logic [63:0]             baddr_ext;
    logic                    word_full;
    logic                    scan_more;
    logic                    region_more;
    logic                    region_live;
    logic                    alloc_fail;
    logic                    free_ok;
    logic [CW1-1:0]          cnt_sum;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [31:0]             wr_data;
    logic [IDX_W-1:0]        rd_addr;

    // Index of the lowest clear bit; only meaningful when the word is not full.
    function automatic logic [4:0] lowest_zero(input logic [31:0] w);
        logic [4:0] pos;
        pos = '0;
        for (int b = 31; b >= 0; b--)
        begin
            if (!w[b])
            begin
                pos = 5'(b);
            end
        end
        return pos;
    endfunction

    // Block total from installed memory, clamped to the map size
    assign tot_raw   = {memory_kb_reg, 10'b0} >> S;
    assign total     = (tot_raw > KBW'(NUM_BLOCKS)) ? CNTW'(NUM_BLOCKS) : CNTW'(tot_raw);
    assign total_ext = 64'(total);
    assign nwords    = total >> 5;

    assign start_ext  = 64'(start_reg);
    assign end_ext    = 64'(end_reg);
    assign start_word = start_ext[IDX_W+4:5];

    assign stop        = (end_ext < total_ext) ? CNTW'(end_reg) : total;
    assign region_live = start_ext < 64'(stop);
    assign free_ok     = start_ext < total_ext;
    assign alloc_fail  = (cnt_reg == '0) || (nwords == '0);

    assign last_frame  = stop_reg - CNTW'(1);
    assign last_ext    = 64'(last_frame);
    assign last_word   = last_ext[IDX_W+4:5];
    assign region_more = CNTW'(idx_reg) < (last_frame >> 5);

    assign lo          = (idx_reg == start_word) ? start_reg[4:0] : 5'd0;
    assign hi          = (idx_reg == last_word) ? last_frame[4:0] : 5'd31;
    assign region_mask = (bfa_pkg::FULL_WORD << lo) & (bfa_pkg::FULL_WORD >> (5'd31 - hi));

    assign word_full = rdata_reg == bfa_pkg::FULL_WORD;
    assign scan_more = (CW1'(idx_reg) + CW1'(1)) < CW1'(nwords);
    assign zero_bit  = lowest_zero(rdata_reg);
    assign frame_ext = 64'({idx_reg, zero_bit});
    assign baddr_ext = frame_ext << S;

    assign dp_status = '{
        kind:        kind_reg,
        init_last:   clr_reg == IDX_W'(MAP_WORDS - 1),
        alloc_fail:  alloc_fail,
        free_ok:     free_ok,
        region_live: region_live,
        word_full:   word_full,
        scan_more:   scan_more,
        region_more: region_more
    };

    // Memory port control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = rdata_reg;
        rd_addr = '0;
        case (op)
            bfa_pkg::DP_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = bfa_pkg::FULL_WORD;
            end
            bfa_pkg::DP_SETUP:
            begin
                rd_addr = (kind_reg == bfa_pkg::KIND_ALLOC) ? '0 : start_word;
            end
            bfa_pkg::DP_SCAN:
            begin
                rd_addr = IDX_W'(idx_reg + 1'b1);
                wr_en   = !word_full;
                wr_data = rdata_reg | (32'd1 << zero_bit);
            end
            bfa_pkg::DP_FREE:
            begin
                wr_en   = 1'b1;
                wr_data = rdata_reg & ~(32'd1 << start_reg[4:0]);
            end
            bfa_pkg::DP_REGION:
            begin
                rd_addr = IDX_W'(idx_reg + 1'b1);
                wr_en   = 1'b1;
                wr_data = (kind_reg == bfa_pkg::KIND_RELEASE) ? (rdata_reg & ~region_mask)
                                                              : (rdata_reg | region_mask);
            end
            bfa_pkg::DP_FORCE_WR:
            begin
                wr_en   = 1'b1;
                wr_data = rdata_reg | 32'd1;
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Free count update
    assign cnt_sum = CW1'(cnt_reg) + CW1'(n_reg);

    always_comb
    begin
        cnt_next = cnt_reg;
        case (op)
            bfa_pkg::DP_SETUP:
            begin
                if (kind_reg == bfa_pkg::KIND_FREE && free_ok && cnt_reg < total)
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            bfa_pkg::DP_SCAN:
            begin
                if (!word_full && cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - CNTW'(1);
                end
            end
            bfa_pkg::DP_REGION:
            begin
                // whole run is counted once, on the last word
                if (!region_more)
                begin
                    if (kind_reg == bfa_pkg::KIND_RELEASE)
                    begin
                        if (cnt_reg < total)
                        begin
                            cnt_next = (cnt_sum > CW1'(total)) ? total : CNTW'(cnt_sum);
                        end
                    end
                    else
                    begin
                        cnt_next = (cnt_reg > n_reg) ? (cnt_reg - n_reg) : '0;
                    end
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            cnt_reg       <= '0;
            memory_kb_reg <= bfa_pkg::MEM_KB_RESET;
        end
        else
        begin
            if (op == bfa_pkg::DP_INIT)
            begin
                clr_reg <= IDX_W'(clr_reg + 1'b1);
            end
            cnt_reg <= cnt_next;
            if (cfg_valid)
            begin
                memory_kb_reg <= cfg_data;
            end
        end
    end

    // Request and response payload
    always_ff @(posedge clk)
    begin
        case (op)
            bfa_pkg::DP_ACCEPT:
            begin
                kind_reg   <= req_data.kind;
                start_reg  <= FW'(req_data.addr >> S);
                end_reg    <= EW'(req_data.addr >> S) + EW'(req_data.length >> S);
                len_nz_reg <= (req_data.length >> S) != '0;
            end
            bfa_pkg::DP_SETUP:
            begin
                baddr_reg  <= '0;
                stop_reg   <= stop;
                n_reg      <= region_live ? (stop - CNTW'(start_reg)) : '0;
                idx_reg    <= (kind_reg == bfa_pkg::KIND_ALLOC) ? '0 : start_word;
                status_reg <= bfa_pkg::STATUS_OK;
                case (kind_reg)
                    bfa_pkg::KIND_ALLOC:
                    begin
                        if (alloc_fail)
                        begin
                            status_reg <= bfa_pkg::STATUS_NO_MEM;
                        end
                    end
                    bfa_pkg::KIND_FREE:
                    begin
                        if (!free_ok)
                        begin
                            status_reg <= bfa_pkg::STATUS_RANGE;
                        end
                    end
                    default:
                    begin
                        if (len_nz_reg && end_ext > total_ext)
                        begin
                            status_reg <= bfa_pkg::STATUS_RANGE;
                        end
                    end
                endcase
            end
            bfa_pkg::DP_SCAN:
            begin
                if (!word_full)
                begin
                    baddr_reg <= baddr_ext[31:0];
                end
                else if (scan_more)
                begin
                    idx_reg <= IDX_W'(idx_reg + 1'b1);
                end
                else
                begin
                    status_reg <= bfa_pkg::STATUS_NO_MEM;
                end
            end
            bfa_pkg::DP_REGION:
            begin
                idx_reg <= IDX_W'(idx_reg + 1'b1);
            end
            bfa_pkg::DP_FORCE_RD:
            begin
                idx_reg <= '0;
            end
            bfa_pkg::DP_LOAD:
            begin
                rsp_reg.status      <= status_reg;
                rsp_reg.block_addr  <= baddr_reg;
                rsp_reg.free_blocks <= 16'(cnt_reg);
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign rsp_data = rsp_reg;

endmodule

[rtl/core/bfa_ctrl.sv]
// Controller: sequences map sweeps, scans and region walks.
module bfa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  bfa_pkg::dp_status_t dp_status,
    output bfa_pkg::dp_op_t     op
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_FREE,
        S_REGION,
        S_FORCE_RD,
        S_FORCE_WR,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   req_ready_reg;
    logic   rsp_valid_reg;
    logic   load;

    assign load = (state_reg == S_RESP) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        op         = bfa_pkg::DP_NONE;
        case (state_reg)
            S_INIT:
            begin
                op = bfa_pkg::DP_INIT;
                if (dp_status.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid && req_ready_reg)
                begin
                    op         = bfa_pkg::DP_ACCEPT;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                op = bfa_pkg::DP_SETUP;
                case (dp_status.kind)
                    bfa_pkg::KIND_ALLOC:
                    begin
                        state_next = dp_status.alloc_fail ? S_RESP : S_SCAN;
                    end
                    bfa_pkg::KIND_FREE:
                    begin
                        state_next = dp_status.free_ok ? S_FREE : S_RESP;
                    end
                    default:
                    begin
                        if (dp_status.region_live)
                        begin
                            state_next = S_REGION;
                        end
                        else if (dp_status.kind == bfa_pkg::KIND_RELEASE)
                        begin
                            state_next = S_FORCE_RD;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                op = bfa_pkg::DP_SCAN;
                if (!dp_status.word_full || !dp_status.scan_more)
                begin
                    state_next = S_RESP;
                end
            end
            S_FREE:
            begin
                op         = bfa_pkg::DP_FREE;
                state_next = S_RESP;
            end
            S_REGION:
            begin
                op = bfa_pkg::DP_REGION;
                if (!dp_status.region_more)
                begin
                    // release always ends by marking block 0 used
                    state_next = (dp_status.kind == bfa_pkg::KIND_RELEASE) ? S_FORCE_RD
                                                                           : S_RESP;
                end
            end
            S_FORCE_RD:
            begin
                op         = bfa_pkg::DP_FORCE_RD;
                state_next = S_FORCE_WR;
            end
            S_FORCE_WR:
            begin
                op         = bfa_pkg::DP_FORCE_WR;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (load)
                begin
                    op         = bfa_pkg::DP_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            req_ready_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_ready_reg <= (state_next == S_IDLE);
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign req_ready = req_ready_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule
